// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising edge, off while reset is held.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same check, for properties that must also hold while reset is held.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/bis_pkg.sv =====
`timescale 1ns / 1ps

package bis_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int FRAC_BITS = 8;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int DIM_W   = 9;
    localparam int COORD_W = 17;
    localparam int PIX_W   = 16;
    localparam int OUT_W   = 24;

    localparam int BANKS   = 4;
    localparam int BANK_AW = (ROW_W - 1) + (COL_W - 1);
    localparam int BANK_DEPTH = (MAX_ROWS / 2) * (MAX_COLS / 2);

    localparam int FR_W   = FRAC_BITS + 1;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int PROD_W = PIX_W + WGT_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic                               is_query;
        logic                               in_image;
        logic [1:0]                         wr_bank;
        logic [PIX_W-1:0]                   wr_value;
        logic [BANKS-1:0][BANK_AW-1:0]      addr;
        logic [BANKS-1:0][WGT_W-1:0]        wgt;
    } job_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(2))
            r = DIM_W'(2);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/bis_ram.sv =====
`timescale 1ns / 1ps

module bis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bis_front.sv =====
`timescale 1ns / 1ps

module bis_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bis_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic [bis_pkg::DIM_W-1:0]       rows_in_use,
    input  logic [bis_pkg::DIM_W-1:0]       cols_in_use,
    input  logic                            q_full,
    output logic                            push,
    output bis_pkg::job_t                   push_job
);

    localparam int RW = bis_pkg::ROW_W;
    localparam int CW = bis_pkg::COL_W;
    localparam int FB = bis_pkg::FRAC_BITS;
    localparam int FW = bis_pkg::FR_W;

    logic                 f_valid_reg, f_valid_next;
    logic                 f_query_reg, f_query_next;
    logic                 f_inside_reg, f_inside_next;
    logic [RW-1:0]        f_i_reg, f_i_next;
    logic [CW-1:0]        f_j_reg, f_j_next;
    logic [FW-1:0]        f_dr_reg, f_dr_next;
    logic [FW-1:0]        f_dc_reg, f_dc_next;
    logic [bis_pkg::PIX_W-1:0] f_val_reg, f_val_next;

    logic                 accept;
    logic [RW-1:0]        hm1;
    logic [CW-1:0]        wm1;
    logic [bis_pkg::COORD_W-1:0] x, y;
    logic [RW-1:0]        i_raw;
    logic [CW-1:0]        j_raw;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = f_valid_reg && !q_full;
    assign s_axis_tready = !f_valid_reg || !q_full;

    assign hm1   = RW'(rows_in_use - bis_pkg::DIM_W'(1));
    assign wm1   = CW'(cols_in_use - bis_pkg::DIM_W'(1));
    assign x     = s_axis_tdata[48:32];
    assign y     = s_axis_tdata[65:49];
    assign i_raw = x[FB +: RW];
    assign j_raw = y[FB +: CW];

    always_comb
    begin
        f_valid_next  = f_valid_reg;
        f_query_next  = f_query_reg;
        f_inside_next = f_inside_reg;
        f_i_next      = f_i_reg;
        f_j_next      = f_j_reg;
        f_dr_next     = f_dr_reg;
        f_dc_next     = f_dc_reg;
        f_val_next    = f_val_reg;
        if (push)
        begin
            f_valid_next = 1'b0;
        end
        if (accept)
        begin
            f_valid_next = 1'b1;
            f_query_next = (bis_pkg::op_t'(s_axis_tuser) == bis_pkg::OP_QUERY);
            f_val_next   = s_axis_tdata[31:16];
            f_inside_next = !x[bis_pkg::COORD_W-1] && !y[bis_pkg::COORD_W-1]
                && !(x[bis_pkg::COORD_W-2:0] > {hm1, FB'(0)})
                && !(y[bis_pkg::COORD_W-2:0] > {wm1, FB'(0)});
            if (bis_pkg::op_t'(s_axis_tuser) == bis_pkg::OP_WRITE)
            begin
                f_i_next = s_axis_tdata[7:0];
                f_j_next = s_axis_tdata[15:8];
            end
            else
            begin
                if (i_raw == hm1)
                begin
                    f_i_next  = i_raw - RW'(1);
                    f_dr_next = FW'(1 << FB);
                end
                else
                begin
                    f_i_next  = i_raw;
                    f_dr_next = {1'b0, x[FB-1:0]};
                end
                if (j_raw == wm1)
                begin
                    f_j_next  = j_raw - CW'(1);
                    f_dc_next = FW'(1 << FB);
                end
                else
                begin
                    f_j_next  = j_raw;
                    f_dc_next = {1'b0, y[FB-1:0]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_query_reg  <= f_query_next;
        f_inside_reg <= f_inside_next;
        f_i_reg      <= f_i_next;
        f_j_reg      <= f_j_next;
        f_dr_reg     <= f_dr_next;
        f_dc_reg     <= f_dc_next;
        f_val_reg    <= f_val_next;
    end

    // Each bank holds one row/column parity, so the four neighbors of a
    // cell always land in four different banks.
    always_comb
    begin
        logic [FW-1:0]   wr0, wc0, wr, wc;
        logic [2*FW-1:0] prod;
        logic [RW-1:0]   r;
        logic [CW-1:0]   c;
        logic            rsel, csel;

        wr0 = FW'(1 << FB) - f_dr_reg;
        wc0 = FW'(1 << FB) - f_dc_reg;
        push_job          = '0;
        push_job.is_query = f_query_reg;
        push_job.in_image = f_inside_reg;
        push_job.wr_bank  = {f_i_reg[0], f_j_reg[0]};
        push_job.wr_value = f_val_reg;
        for (int b = 0; b < bis_pkg::BANKS; b++)
        begin
            rsel = (b[1] == f_i_reg[0]);
            csel = (b[0] == f_j_reg[0]);
            wr   = rsel ? wr0 : f_dr_reg;
            wc   = csel ? wc0 : f_dc_reg;
            prod = wr * wc;
            r    = rsel ? f_i_reg : f_i_reg + RW'(1);
            c    = csel ? f_j_reg : f_j_reg + CW'(1);
            push_job.wgt[b] = prod[bis_pkg::WGT_W-1:0];
            if (f_query_reg)
                push_job.addr[b] = {r[RW-1:1], c[CW-1:1]};
            else
                push_job.addr[b] = {f_i_reg[RW-1:1], f_j_reg[CW-1:1]};
        end
    end

endmodule

// ===== rtl/bis_queue.sv =====
`timescale 1ns / 1ps

module bis_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bis_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output bis_pkg::job_t  head_job
);

    localparam int AW = bis_pkg::QUEUE_AW;

    bis_pkg::job_t  slots_reg [bis_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign full     = (count_reg == (AW+1)'(bis_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/bis_back.sv =====
`timescale 1ns / 1ps

module bis_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  bis_pkg::job_t                  head_job,
    output logic                           pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bis_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tuser
);

    localparam int PW = bis_pkg::PROD_W;
    localparam int AW = bis_pkg::ACC_W;

    logic                                    advance;
    logic [bis_pkg::BANKS-1:0]               we, re;
    logic [bis_pkg::BANKS-1:0][bis_pkg::PIX_W-1:0] rdata;

    logic                                    s1_valid_reg, s1_valid_next;
    logic                                    s1_inside_reg, s1_inside_next;
    logic [bis_pkg::BANKS-1:0][bis_pkg::WGT_W-1:0] s1_wgt_reg, s1_wgt_next;
    logic                                    s2_valid_reg, s2_valid_next;
    logic                                    s2_inside_reg, s2_inside_next;
    logic [bis_pkg::BANKS-1:0][PW-1:0]       s2_prod_reg, s2_prod_next;
    logic                                    m_valid_reg, m_valid_next;
    logic                                    m_inside_reg, m_inside_next;
    logic [bis_pkg::OUT_W-1:0]               m_sample_reg, m_sample_next;
    logic [AW-1:0]                           acc;

    assign advance = !m_valid_reg || m_axis_tready;
    assign pop     = advance && q_valid;

    for (genvar b = 0; b < bis_pkg::BANKS; b++)
    begin : g_bank
        assign we[b] = pop && !head_job.is_query && (head_job.wr_bank == 2'(b));
        assign re[b] = pop && head_job.is_query && head_job.in_image;

        bis_ram #(
            .WIDTH (bis_pkg::PIX_W),
            .DEPTH (bis_pkg::BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we[b]),
            .waddr (head_job.addr[b]),
            .wdata (head_job.wr_value),
            .re    (re[b]),
            .raddr (head_job.addr[b]),
            .rdata (rdata[b])
        );
    end

    always_comb
    begin
        acc = AW'(s2_prod_reg[0]) + AW'(s2_prod_reg[1])
            + AW'(s2_prod_reg[2]) + AW'(s2_prod_reg[3])
            + AW'(1 << (bis_pkg::FRAC_BITS - 1));
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_inside_next = s1_inside_reg;
        s1_wgt_next    = s1_wgt_reg;
        s2_valid_next  = s2_valid_reg;
        s2_inside_next = s2_inside_reg;
        s2_prod_next   = s2_prod_reg;
        m_valid_next   = m_valid_reg;
        m_inside_next  = m_inside_reg;
        m_sample_next  = m_sample_reg;
        if (advance)
        begin
            s1_valid_next  = pop && head_job.is_query;
            s1_inside_next = head_job.in_image;
            s1_wgt_next    = head_job.wgt;
            s2_valid_next  = s2_valid_reg;
            s2_valid_next  = s1_valid_reg;
            s2_inside_next = s1_inside_reg;
            for (int b = 0; b < bis_pkg::BANKS; b++)
            begin
                s2_prod_next[b] = PW'(rdata[b] * s1_wgt_reg[b]);
            end
            m_valid_next  = s2_valid_reg;
            m_inside_next = s2_inside_reg;
            m_sample_next = s2_inside_reg ? acc[bis_pkg::FRAC_BITS +: bis_pkg::OUT_W] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_inside_reg <= s1_inside_next;
        s1_wgt_reg    <= s1_wgt_next;
        s2_inside_reg <= s2_inside_next;
        s2_prod_reg   <= s2_prod_next;
        m_inside_reg  <= m_inside_next;
        m_sample_reg  <= m_sample_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_inside_reg;
    assign m_axis_tdata  = m_sample_reg;

endmodule

// ===== rtl/bilinear_image_sampler.sv =====
`timescale 1ns / 1ps

// Bilinear image sampler over a 256 x 256 store of 16-bit pixels.
// The slave stream carries items: tuser low writes one pixel, tuser high
// queries a point given in signed fixed point with 8 fraction bits.
// A write produces no transfer on the master stream. A query produces one
// transfer: tuser says whether the point lies inside the image, tdata holds
// the interpolated value with 8 fraction bits, or zero when outside.
// The configuration channel sets the rows and columns in use; it is always
// ready. The user must write it only while the block is idle; the block
// does not enforce this. A query passes the classify, queue, RAM read,
// product and result registers. One item is accepted per cycle while the
// queue has room; the four neighbors come from four RAM banks split by row
// and column parity, read in parallel. A queue of four items separates the
// classify stage from the RAM and multiply pipeline. When the receiver
// stalls, the result register holds, the pipeline freezes, the queue fills
// and then tready drops. Reset clears the control state and sets both
// dimensions to 256; pixel content is undefined until written.
module bilinear_image_sampler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pixel_row, pixel_col, pixel_value, coord_row, coord_col, zero fill
    input  logic [bis_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sample_value
    output logic [bis_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // point_inside
    output logic                            m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bis_pkg::DIM_W-1:0]       cfg_data
);

    logic [bis_pkg::DIM_W-1:0] rows_reg, rows_next;
    logic [bis_pkg::DIM_W-1:0] cols_reg, cols_next;
    logic                      q_full, push, pop, q_valid;
    bis_pkg::job_t             push_job, head_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bis_pkg::CFG_ROWS:
                    rows_next = bis_pkg::clamp_dim(cfg_data,
                                                   bis_pkg::DIM_W'(bis_pkg::MAX_ROWS));
                bis_pkg::CFG_COLS:
                    cols_next = bis_pkg::clamp_dim(cfg_data,
                                                   bis_pkg::DIM_W'(bis_pkg::MAX_COLS));
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= bis_pkg::DIM_W'(bis_pkg::MAX_ROWS);
            cols_reg <= bis_pkg::DIM_W'(bis_pkg::MAX_COLS);
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    bis_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .rows_in_use   (rows_reg),
        .cols_in_use   (cols_reg),
        .q_full        (q_full),
        .push          (push),
        .push_job      (push_job)
    );

    bis_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_job (head_job)
    );

    bis_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/bis_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bis_assert_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [bis_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                            m_axis_tuser
);

    // A stalled result keeps its value until the transfer completes.
    `ASSERT_CLKD(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser),
        "result changed while stalled")

    // A point outside the image always reports a zero sample.
    `ASSERT_CLKD(a_outside_zero, clk, rst_n,
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0,
        "outside point with nonzero sample")

    // The mix of four 16-bit pixels never exceeds full scale.
    `ASSERT_CLKD(a_full_scale, clk, rst_n,
        m_axis_tvalid |-> m_axis_tdata <= bis_pkg::M_TDATA_W'(24'hFFFF00),
        "sample above full scale")

    // No result is offered once reset has been held over a clock edge.
    `ASSERT_CLK(a_reset_quiet, clk,
        !rst_n && $past(!rst_n) |-> !m_axis_tvalid,
        "result offered during reset")

endmodule

bind bilinear_image_sampler bis_assert_checker u_bis_assert_checker (.*);

// ===== dv/bis_checker.sv =====
`timescale 1ns / 1ps

module bis_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // pixel_row, pixel_col, pixel_value, coord_row, coord_col, zero fill
    input  logic [bis_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sample_value
    input  logic [bis_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // point_inside
    input  logic                            m_axis_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bis_pkg::DIM_W-1:0]       cfg_data,
    output int                              mismatches,
    output int                              pending
);
    import bis_pkg::*;

    localparam int SCALE     = 1 << FRAC_BITS;
    localparam int VALUE_LSB = ROW_W + COL_W;
    localparam int CROW_LSB  = VALUE_LSB + PIX_W;
    localparam int CCOL_LSB  = CROW_LSB + COORD_W;

    typedef struct packed {
        logic               in_image;
        logic [OUT_W-1:0]   value;
    } sample_t;

    logic [PIX_W-1:0] image_copy [MAX_ROWS*MAX_COLS];
    sample_t          samples_due [$];
    int               rows_now   = MAX_ROWS;
    int               cols_now   = MAX_COLS;
    int               fail_total = 0;

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic int bounded_dim(input logic [DIM_W-1:0] code, input int hi);
        int d;
        d = int'(code);
        if (d < 2)
            d = 2;
        else if (d > hi)
            d = hi;
        return d;
    endfunction

    function automatic sample_t predict_sample(input logic [COORD_W-1:0] row_fx,
                                               input logic [COORD_W-1:0] col_fx);
        int                r;
        int                c;
        int                i;
        int                j;
        longint unsigned   wr;
        longint unsigned   wc;
        longint unsigned   acc;
        sample_t           s;
        r = $signed(row_fx);
        c = $signed(col_fx);
        s = '0;
        if (r < 0 || c < 0 || r > (rows_now - 1) * SCALE || c > (cols_now - 1) * SCALE)
            return s;
        i = r / SCALE;
        j = c / SCALE;
        if (i == rows_now - 1)
            i--;
        if (j == cols_now - 1)
            j--;
        wr = longint'(r - i * SCALE);
        wc = longint'(c - j * SCALE);
        acc = longint'(image_copy[i * MAX_COLS + j]) * (SCALE - wr) * (SCALE - wc)
            + longint'(image_copy[(i + 1) * MAX_COLS + j]) * wr * (SCALE - wc)
            + longint'(image_copy[i * MAX_COLS + j + 1]) * (SCALE - wr) * wc
            + longint'(image_copy[(i + 1) * MAX_COLS + j + 1]) * wr * wc;
        s.in_image = 1'b1;
        s.value    = OUT_W'((acc + SCALE / 2) >> FRAC_BITS);
        return s;
    endfunction

    always @(posedge clk)
    begin : watch_channels
        sample_t due;
        sample_t seen;
        int      addr;
        if (!rst_n)
        begin
            rows_now = MAX_ROWS;
            cols_now = MAX_COLS;
            samples_due.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.in_image = m_axis_tuser;
                seen.value    = m_axis_tdata;
                if (samples_due.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected result transfer: point_inside %0b sample_value 0x%06h",
                             $time, seen.in_image, seen.value);
                end
                else
                begin
                    due = samples_due.pop_front();
                    if (seen.in_image !== due.in_image)
                    begin
                        fail_total++;
                        $display("%0t: point_inside expected %0b actual %0b",
                                 $time, due.in_image, seen.in_image);
                    end
                    if (seen.value !== due.value)
                    begin
                        fail_total++;
                        $display("%0t: sample_value expected 0x%06h actual 0x%06h",
                                 $time, due.value, seen.value);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_QUERY)
                begin
                    samples_due.push_back(predict_sample(s_axis_tdata[CROW_LSB +: COORD_W],
                                                         s_axis_tdata[CCOL_LSB +: COORD_W]));
                end
                else
                begin
                    addr = int'(s_axis_tdata[0 +: ROW_W]) * MAX_COLS
                         + int'(s_axis_tdata[ROW_W +: COL_W]);
                    image_copy[addr] = s_axis_tdata[VALUE_LSB +: PIX_W];
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROWS: rows_now = bounded_dim(cfg_data, MAX_ROWS);
                    CFG_COLS: cols_now = bounded_dim(cfg_data, MAX_COLS);
                    default:  ;
                endcase
            end
        end
        mismatches <= fail_total;
        pending    <= samples_due.size();
    end

endmodule

// ===== dv/tb_bilinear_image_sampler.sv =====
`timescale 1ns / 1ps

module tb_bilinear_image_sampler;
    import bis_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int SCALE         = 1 << FRAC_BITS;
    localparam int FIELD_BITS    = ROW_W + COL_W + PIX_W + 2 * COORD_W;
    localparam int ITEM_BUDGET   = 1400;
    localparam int SETTLE_CYCLES = 12;
    localparam int SQUEEZE_HOLD  = 150;
    localparam int SQUEEZE_BURST = 48;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [DIM_W-1:0]       cfg_data      = '0;
    logic                   squeeze_req   = 1'b0;

    int mismatches;
    int pending;
    int rows_cur   = MAX_ROWS;
    int cols_cur   = MAX_COLS;
    int items_sent = 0;
    bit written [MAX_ROWS*MAX_COLS];

    bilinear_image_sampler i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    bis_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_bilinear_image_sampler: FAIL");
        $finish;
    end

    // The receiver runs in stretches of ready and not ready; a squeeze request
    // forces one long hold so that the block backs up into its input.
    initial
    begin : result_sink
        int  run_left;
        bit  run_ready;
        bit  squeeze_taken;
        int  pick;
        run_left      = 0;
        run_ready     = 1'b0;
        squeeze_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_taken)
            begin
                squeeze_taken = 1'b1;
                run_ready     = 1'b0;
                run_left      = SQUEEZE_HOLD;
            end
            if (!squeeze_req)
                squeeze_taken = 1'b0;
            if (run_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    run_ready = 1'b1;
                    run_left  = $urandom_range(1, 30);
                end
                else if (pick < 92)
                begin
                    run_ready = 1'b0;
                    run_left  = $urandom_range(1, 3);
                end
                else
                begin
                    run_ready = 1'b0;
                    run_left  = $urandom_range(10, 60);
                end
            end
            m_axis_tready <= run_ready;
            run_left--;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(input logic [ROW_W-1:0]   pix_row,
                                                       input logic [COL_W-1:0]   pix_col,
                                                       input logic [PIX_W-1:0]   pix_value,
                                                       input logic [COORD_W-1:0] crd_row,
                                                       input logic [COORD_W-1:0] crd_col);
        return {{(S_TDATA_W - FIELD_BITS){1'b0}}, crd_col, crd_row, pix_value, pix_col, pix_row};
    endfunction

    function automatic logic [DIM_W-1:0] dim_code(input int d, input int hi);
        logic [DIM_W-1:0] code;
        code = DIM_W'(d);
        if (d == 2 && $urandom_range(0, 2) == 0)
            code = DIM_W'($urandom_range(0, 1));
        else if (d == hi && $urandom_range(0, 2) == 0)
            code = DIM_W'($urandom_range(hi + 1, (1 << DIM_W) - 1));
        return code;
    endfunction

    function automatic int inside_coord(input int dim);
        int c;
        case ($urandom_range(0, 9))
            0:       c = 0;
            1:       c = (dim - 1) * SCALE;
            2:       c = $urandom_range(0, dim - 1) * SCALE + SCALE / 2;
            default: c = $urandom_range(0, (dim - 1) * SCALE);
        endcase
        if (c > (dim - 1) * SCALE)
            c = (dim - 1) * SCALE;
        return c;
    endfunction

    task automatic offer(input op_t op, input logic [S_TDATA_W-1:0] data, input bit no_gap);
        int gap;
        int pick;
        gap = 0;
        if (!no_gap)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                gap = 0;
            else if (pick < 90)
                gap = $urandom_range(1, 3);
            else if (pick < 98)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 50);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_pixel(input int r, input int c, input logic [PIX_W-1:0] v,
                               input bit no_gap);
        offer(OP_WRITE, pack_item(r[ROW_W-1:0], c[COL_W-1:0], v,
                                  COORD_W'($urandom), COORD_W'($urandom)), no_gap);
        written[r * MAX_COLS + c] = 1'b1;
    endtask

    // Any neighbor of an inside point that has never been loaded is loaded first.
    task automatic query_point(input int rv, input int cv, input bit no_gap);
        int i;
        int j;
        if (rv >= 0 && cv >= 0 && rv <= (rows_cur - 1) * SCALE && cv <= (cols_cur - 1) * SCALE)
        begin
            i = rv / SCALE;
            j = cv / SCALE;
            if (i == rows_cur - 1)
                i--;
            if (j == cols_cur - 1)
                j--;
            for (int k = 0; k < 4; k++)
            begin
                if (!written[(i + k / 2) * MAX_COLS + j + k % 2])
                    write_pixel(i + k / 2, j + k % 2, PIX_W'($urandom), no_gap);
            end
        end
        offer(OP_QUERY, pack_item(ROW_W'($urandom), COL_W'($urandom), PIX_W'($urandom),
                                  rv[COORD_W-1:0], cv[COORD_W-1:0]), no_gap);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int rows_target, input int cols_target);
        settle();
        set_register(CFG_ROWS, dim_code(rows_target, MAX_ROWS));
        set_register(CFG_COLS, dim_code(cols_target, MAX_COLS));
        if ($urandom_range(0, 3) == 0)
            set_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, DIM_W'($urandom));
        rows_cur = rows_target;
        cols_cur = cols_target;
    endtask

    initial
    begin : stimulus
        int phase;
        int rows_pick;
        int cols_pick;
        int left;
        int pick;
        int rv;
        int cv;
        phase = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest image, with dimension codes below the legal range and a spare index.
        set_register(CFG_ROWS, 9'd0);
        set_register(CFG_COLS, 9'd1);
        set_register(CFG_SPARE_LO, 9'd5);
        rows_cur = 2;
        cols_cur = 2;
        write_pixel(0, 0, 16'h0000, 1'b0);
        write_pixel(0, 1, 16'hFFFF, 1'b0);
        write_pixel(1, 0, 16'hFFFF, 1'b0);
        write_pixel(1, 1, 16'h0080, 1'b0);
        query_point(0, 0, 1'b0);
        query_point(SCALE, SCALE, 1'b0);
        query_point(SCALE / 2, SCALE / 2, 1'b0);
        query_point(1, 1, 1'b0);
        query_point(SCALE, 0, 1'b0);
        query_point(-1, 0, 1'b0);
        query_point(0, SCALE + 1, 1'b0);
        query_point(-65536, 65535, 1'b0);
        // Pixels beyond the rows in use are still stored.
        write_pixel(200, 100, 16'h1234, 1'b0);
        write_pixel(201, 100, 16'hABCD, 1'b0);
        write_pixel(200, 101, 16'hFFFF, 1'b0);
        write_pixel(201, 101, 16'h0001, 1'b0);

        // Largest image, with one dimension code above the legal range and one at its upper bound.
        settle();
        set_register(CFG_ROWS, 9'h1FF);
        set_register(CFG_COLS, 9'd256);
        set_register(CFG_SPARE_HI, 9'h100);
        rows_cur = MAX_ROWS;
        cols_cur = MAX_COLS;
        query_point(200 * SCALE + SCALE / 2, 100 * SCALE + 77, 1'b0);
        query_point((MAX_ROWS - 1) * SCALE, (MAX_COLS - 1) * SCALE, 1'b0);
        query_point(65535, 0, 1'b0);

        while (items_sent < ITEM_BUDGET)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    rows_pick = 2;
                    cols_pick = MAX_COLS;
                end
                1:
                begin
                    rows_pick = MAX_ROWS;
                    cols_pick = 2;
                end
                2:
                begin
                    rows_pick = MAX_ROWS;
                    cols_pick = MAX_COLS;
                end
                3:
                begin
                    rows_pick = 2;
                    cols_pick = 2;
                end
                4, 5, 6, 7:
                begin
                    rows_pick = $urandom_range(2, 12);
                    cols_pick = $urandom_range(2, 12);
                end
                default:
                begin
                    rows_pick = $urandom_range(2, MAX_ROWS);
                    cols_pick = $urandom_range(2, MAX_COLS);
                end
            endcase
            configure(rows_pick, cols_pick);

            if (phase % 3 == 0)
            begin
                squeeze_req <= 1'b1;
                repeat (SQUEEZE_BURST)
                    query_point(inside_coord(rows_cur), inside_coord(cols_cur), 1'b1);
                squeeze_req <= 1'b0;
            end

            left = $urandom_range(40, 120);
            while (left > 0 && items_sent < ITEM_BUDGET)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    write_pixel($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                                PIX_W'($urandom), 1'b0);
                end
                else if (pick < 27)
                begin
                    rv = $urandom_range(0, 131071) - 65536;
                    cv = $urandom_range(0, 131071) - 65536;
                    case ($urandom_range(0, 3))
                        0:       rv = -$urandom_range(1, 65536);
                        1:       rv = $urandom_range((rows_cur - 1) * SCALE + 1, 65535);
                        2:       cv = -$urandom_range(1, 65536);
                        default: cv = $urandom_range((cols_cur - 1) * SCALE + 1, 65535);
                    endcase
                    query_point(rv, cv, 1'b0);
                end
                else
                begin
                    query_point(inside_coord(rows_cur), inside_coord(cols_cur), 1'b0);
                end
                left--;
            end
            phase++;
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("tb_bilinear_image_sampler: PASS");
        else
            $display("tb_bilinear_image_sampler: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bis_pkg.sv
rtl/bis_ram.sv
rtl/bis_front.sv
rtl/bis_queue.sv
rtl/bis_back.sv
rtl/bilinear_image_sampler.sv
rtl/bis_checker.sv
dv/bis_checker.sv
dv/tb_bilinear_image_sampler.sv
